[sv/efr_pkg.sv]
package efr_pkg;

  localparam int TileSizeDefault = 8;
  localparam int CoordW = 3;
  localparam int ColorW = 32;

  typedef logic [CoordW-1:0] coord_t;

  // Latched vertex set, shared between the sequencer and the edge unit.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } vtx_t;

endpackage

[sv/efr_edge_eval.sv]
module efr_edge_eval
  import efr_pkg::*;
(
  input  vtx_t   vtx_i,
  input  coord_t px_i,
  input  coord_t py_i,
  output logic   covered_o
);

  localparam int ProdW = 2*CoordW + 2;

  function automatic logic signed [CoordW:0] sdiff(coord_t a, coord_t b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // Non-negative cross(u, v) = u.x*v.y - v.x*u.y
  function automatic logic edge_ok(logic signed [CoordW:0] ux, logic signed [CoordW:0] uy,
                                   logic signed [CoordW:0] vx, logic signed [CoordW:0] vy);
    logic signed [2*CoordW+1:0] p0;
    logic signed [2*CoordW+1:0] p1;
    logic [2*CoordW+2:0] d;
    p0 = ProdW'(ux) * ProdW'(vy);
    p1 = ProdW'(vx) * ProdW'(uy);
    d  = {p0[2*CoordW+1], p0} - {p1[2*CoordW+1], p1};
    return !d[2*CoordW+2];
  endfunction

  logic e0, e1, e2;

  assign e0 = edge_ok(sdiff(vtx_i.bx, vtx_i.ax), sdiff(vtx_i.by, vtx_i.ay),
                      sdiff(px_i, vtx_i.ax), sdiff(py_i, vtx_i.ay));
  assign e1 = edge_ok(sdiff(vtx_i.cx, vtx_i.bx), sdiff(vtx_i.cy, vtx_i.by),
                      sdiff(px_i, vtx_i.bx), sdiff(py_i, vtx_i.by));
  assign e2 = edge_ok(sdiff(vtx_i.ax, vtx_i.cx), sdiff(vtx_i.ay, vtx_i.cy),
                      sdiff(px_i, vtx_i.cx), sdiff(py_i, vtx_i.cy));

  assign covered_o = e0 & e1 & e2;

endmodule

[sv/edge_function_triangle_raster_unit.sv]
// The first pixel word is registered once a second covered pixel is found, or else in the flush state.
// The shared edge unit tests one bounding-box pixel per cycle, held only while a covered
//   pixel must release the held one into a stalled output.
// in_ready_o is high only while no triangle is being walked; an output stall can hold the walk.
// Reset (rst_ni low, asynchronous): sequencer to idle, pending pixel and output word invalid.
module edge_function_triangle_raster_unit
  import efr_pkg::*;
#(
  parameter int TILE_SIZE = TileSizeDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] vertex_a_x_i,
  input  logic [CoordW-1:0] vertex_a_y_i,
  input  logic [CoordW-1:0] vertex_b_x_i,
  input  logic [CoordW-1:0] vertex_b_y_i,
  input  logic [CoordW-1:0] vertex_c_x_i,
  input  logic [CoordW-1:0] vertex_c_y_i,
  input  logic [ColorW-1:0] fill_color_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [ColorW-1:0] pixel_color_o,
  output logic              last_pixel_o
);

  // Sequencer codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWalk  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  localparam coord_t MaxCoord = CoordW'(TILE_SIZE - 1);

  // Saturate a coordinate to the tile
  function automatic coord_t clamp(coord_t v);
    return (v > MaxCoord) ? MaxCoord : v;
  endfunction

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic [1:0]        state_q, state_d;
  vtx_t              vtx_q, vtx_d, vtx_in;
  logic [ColorW-1:0] color_q, color_d;
  coord_t            min_x_q, min_x_d, min_y_q, min_y_d;
  coord_t            max_x_q, max_x_d, max_y_q, max_y_d;
  coord_t            col_q, col_d, row_q, row_d;
  logic              pend_vld_q, pend_vld_d;
  coord_t            pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic              out_vld_q, out_vld_d;
  coord_t            out_x_q, out_x_d, out_y_q, out_y_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic              out_last_q, out_last_d;

  logic covered;
  logic out_free;
  logic in_acc;

  // Shared edge unit: edge functions of all triangle edges at the current walk pixel
  efr_edge_eval u_edge (
    .vtx_i     (vtx_q),
    .px_i      (col_q),
    .py_i      (row_q),
    .covered_o (covered)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    vtx_in.ax = clamp(vertex_a_x_i);
    vtx_in.ay = clamp(vertex_a_y_i);
    vtx_in.bx = clamp(vertex_b_x_i);
    vtx_in.by = clamp(vertex_b_y_i);
    vtx_in.cx = clamp(vertex_c_x_i);
    vtx_in.cy = clamp(vertex_c_y_i);
  end

  always_comb begin
    state_d     = state_q;
    vtx_d       = vtx_q;
    color_d     = color_q;
    min_x_d     = min_x_q;
    min_y_d     = min_y_q;
    max_x_d     = max_x_q;
    max_y_d     = max_y_q;
    col_d       = col_q;
    row_d       = row_q;
    pend_vld_d  = pend_vld_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    // drop the output word once taken
    out_vld_d   = out_vld_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          vtx_d      = vtx_in;
          color_d    = fill_color_i;
          min_x_d    = min3(vtx_in.ax, vtx_in.bx, vtx_in.cx);
          min_y_d    = min3(vtx_in.ay, vtx_in.by, vtx_in.cy);
          max_x_d    = max3(vtx_in.ax, vtx_in.bx, vtx_in.cx);
          max_y_d    = max3(vtx_in.ay, vtx_in.by, vtx_in.cy);
          col_d      = min3(vtx_in.ax, vtx_in.bx, vtx_in.cx);
          row_d      = min3(vtx_in.ay, vtx_in.by, vtx_in.cy);
          pend_vld_d = 1'b0;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        // A covered pixel releases the held one; hold the walk if that release meets a full output
        if (!(covered && pend_vld_q && !out_free)) begin
          if (covered) begin
            if (pend_vld_q) begin
              out_vld_d   = 1'b1;
              out_x_d     = pend_x_q;
              out_y_d     = pend_y_q;
              out_color_d = color_q;
              out_last_d  = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_x_d   = col_q;
            pend_y_d   = row_q;
          end
          // advance: rows inner, columns outer
          if (row_q == max_y_q) begin
            row_d = min_y_q;
            if (col_q == max_x_q) begin
              state_d = StFlush;
            end else begin
              col_d = col_q + coord_t'(1);
            end
          end else begin
            row_d = row_q + coord_t'(1);
          end
        end
      end
      StFlush: begin
        if (!pend_vld_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_vld_d   = 1'b1;
          out_x_d     = pend_x_q;
          out_y_d     = pend_y_q;
          out_color_d = color_q;
          out_last_d  = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q       <= vtx_d;
    color_q     <= color_d;
    min_x_q     <= min_x_d;
    min_y_q     <= min_y_d;
    max_x_q     <= max_x_d;
    max_y_q     <= max_y_d;
    col_q       <= col_d;
    row_q       <= row_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_pixel_o  = out_last_q;

endmodule

[sv/efr_checker.sv]
module efr_checker #(
  parameter int TILE_SIZE = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  pixel_x_o,
  input logic [2:0]  pixel_y_o,
  input logic [31:0] pixel_color_o,
  input logic        last_pixel_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("output word changed while stalled");

  // a taken triangle closes the input side for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a triangle was taken");

  // pixels stay inside the tile
  a_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(pixel_x_o) < TILE_SIZE) && (32'(pixel_y_o) < TILE_SIZE))
    else $error("pixel outside the tile");

  // a non-last pixel word means the walk is still running
  a_walk_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_pixel_o |-> !in_ready_o)
    else $error("input ready while a triangle still has pixels to come");

endmodule

bind edge_function_triangle_raster_unit efr_checker #(.TILE_SIZE(TILE_SIZE)) u_efr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .last_pixel_o  (last_pixel_o)
);
